@@ rtl/chord_pitch_set_identifier_assert.svh @@
// Assertion macros for the chord pitch-set identifier.
`ifndef CHORD_PITCH_SET_IDENTIFIER_ASSERT_SVH
`define CHORD_PITCH_SET_IDENTIFIER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CPSI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CPSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cpsi_pkg.sv @@
// Shared types, constants and helper functions of the chord pitch-set identifier.
`default_nettype none

package cpsi_pkg;

   localparam int ClassCount    = 12;
   localparam int TemplateCount = 16;

   typedef logic [11:0] mask_type;
   typedef logic [3:0]  class_type;
   typedef logic [4:0]  count_type;
   typedef logic [4:0]  quality_type;
   typedef logic [6:0]  pitch_type;

   typedef enum logic [1:0] {
      StAccum,
      StScan,
      StSend
   } state_type;

   localparam class_type   LastClass = 4'd11;
   localparam count_type   CountSat  = 5'd31;
   localparam quality_type QualNone  = 5'd0;
   localparam logic [4:0]  NoClass   = 5'h1f;

   // Interval templates in rank order: major .. dim7, then the power chord.
   localparam mask_type Templates [TemplateCount] = '{
      12'h091,  // major
      12'h089,  // minor
      12'h491,  // 7
      12'h489,  // m7
      12'h891,  // maj7
      12'h291,  // 6
      12'h289,  // m6
      12'h0a1,  // sus4
      12'h085,  // sus2
      12'h095,  // add9
      12'h08d,  // madd9
      12'h049,  // dim
      12'h111,  // aug
      12'h449,  // m7b5
      12'h249,  // dim7
      12'h081   // power chord: root and fifth
   };

   // Pitch class of a MIDI note: quotient by 12 through a reciprocal multiply,
   // exact for every 7-bit value.
   function automatic class_type note_class(input pitch_type p);
      logic [12:0] prod;
      logic [3:0]  quot;
      logic [7:0]  rem;
      prod = 13'(p) * 13'd43;
      quot = prod[12:9];
      rem  = 8'(p) - 8'(quot) * 8'(ClassCount);
      return rem[3:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/cpsi_root_match.sv @@
// Shared unit: rotates the class mask to one root and matches it against the templates.
`default_nettype none

module cpsi_root_match (
   input  wire cpsi_pkg::mask_type    mask,
   input  wire cpsi_pkg::class_type   root,
   output logic                       hit,
   output cpsi_pkg::quality_type      rank
);

   logic [23:0]        doubled;
   cpsi_pkg::mask_type rotated;

   // Rotate so that the root sits at interval zero
   assign doubled = {mask, mask} >> root;
   assign rotated = doubled[11:0];

   // Compare against every template; the first equal one gives the rank
   always_comb begin
      hit  = 1'b0;
      rank = cpsi_pkg::QualNone;
      for (int t = cpsi_pkg::TemplateCount - 1; t >= 0; t--) begin
         if (rotated == cpsi_pkg::Templates[t]) begin
            hit  = 1'b1;
            rank = 5'(t + 1);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/chord_pitch_set_identifier.sv @@
// Top level of the chord pitch-set identifier: accumulator, root scan sequencer and result register.
//
// Usage: pitches of one chord enter on the req_ stream, one MIDI note per
// request, req_tlast set on the closing note. Notes without tlast are taken
// one per cycle and only accumulated (class mask, lowest note, count).
// On the closing note the block scans the twelve roots, one per cycle,
// through a single rotate-and-match unit, keeping the best match (bass as
// root first, then lower quality rank, then lower root). The result is valid
// on rsp_ once the scan has passed the last root; a chord longer than
// MAX_PITCHES skips the scan and its result is valid the next cycle.
// req_tready is low from the closing note until the result is taken.
// A stalled receiver simply holds the result in the output register.
// Reset is synchronous: it clears the accumulated chord and returns the
// block to accepting notes with no result pending.
`default_nettype none
`include "chord_pitch_set_identifier_assert.svh"

module chord_pitch_set_identifier #(
   parameter int MAX_PITCHES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [6:0] pitch, [7] zero
   input  wire         req_tlast,   // last_pitch
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // [0] chord_named, [5:1] chord_quality,
                                    // [10:6] root_class, [15:11] bass_class
);

   localparam cpsi_pkg::count_type MaxCount = cpsi_pkg::count_type'(MAX_PITCHES);

   cpsi_pkg::state_type   state_ff, state_in;
   cpsi_pkg::mask_type    mask_ff, mask_in;
   cpsi_pkg::pitch_type   low_ff, low_in;
   cpsi_pkg::count_type   count_ff, count_in;
   cpsi_pkg::class_type   bass_ff, bass_in;
   cpsi_pkg::class_type   root_ff, root_in;
   logic                  found_ff, found_in;
   logic                  best_ob_ff, best_ob_in;
   cpsi_pkg::quality_type lead_rank_ff, lead_rank_in;
   cpsi_pkg::class_type   lead_root_ff, lead_root_in;
   logic                  named_ff, named_in;
   cpsi_pkg::quality_type qual_ff, qual_in;
   logic [4:0]            root_out_ff, root_out_in;
   logic [4:0]            bass_out_ff, bass_out_in;

   cpsi_pkg::pitch_type   pitch;
   logic                  hit;
   cpsi_pkg::quality_type rank;
   logic                  cand_ob;
   logic                  better;

   assign pitch = req_tdata[6:0];

   // Shared rotate-and-match unit, stepped over the roots
   cpsi_root_match u_match (
      .mask (mask_ff),
      .root (root_ff),
      .hit  (hit),
      .rank (rank)
   );

   assign cand_ob = (root_ff != bass_ff);
   assign better  = hit && (!found_ff || ({cand_ob, rank} < {best_ob_ff, lead_rank_ff}));

   // Next state, accumulation, scan and result
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      low_in       = low_ff;
      count_in     = count_ff;
      bass_in      = bass_ff;
      root_in      = root_ff;
      found_in     = found_ff;
      best_ob_in   = best_ob_ff;
      lead_rank_in = lead_rank_ff;
      lead_root_in = lead_root_ff;
      named_in     = named_ff;
      qual_in      = qual_ff;
      root_out_in  = root_out_ff;
      bass_out_in  = bass_out_ff;
      req_tready   = (state_ff == cpsi_pkg::StAccum);
      rsp_tvalid   = (state_ff == cpsi_pkg::StSend);
      case (state_ff)
         cpsi_pkg::StAccum: begin
            if (req_tvalid) begin
               low_in   = (count_ff == '0 || pitch < low_ff) ? pitch : low_ff;
               mask_in  = mask_ff | (12'b1 << cpsi_pkg::note_class(pitch));
               count_in = (count_ff != cpsi_pkg::CountSat) ? count_ff + 5'd1 : count_ff;
               if (req_tlast) begin
                  bass_in = cpsi_pkg::note_class(low_in);
                  if (count_in > MaxCount) begin
                     named_in    = 1'b0;
                     qual_in     = cpsi_pkg::QualNone;
                     root_out_in = cpsi_pkg::NoClass;
                     bass_out_in = cpsi_pkg::NoClass;
                     state_in    = cpsi_pkg::StSend;
                  end else begin
                     root_in  = '0;
                     found_in = 1'b0;
                     state_in = cpsi_pkg::StScan;
                  end
               end
            end
         end
         cpsi_pkg::StScan: begin
            if (better) begin
               found_in     = 1'b1;
               best_ob_in   = cand_ob;
               lead_rank_in = rank;
               lead_root_in = root_ff;
            end
            if (root_ff == cpsi_pkg::LastClass) begin
               named_in    = found_in;
               qual_in     = found_in ? lead_rank_in : cpsi_pkg::QualNone;
               root_out_in = found_in ? {1'b0, lead_root_in} : cpsi_pkg::NoClass;
               bass_out_in = {1'b0, bass_ff};
               state_in    = cpsi_pkg::StSend;
            end else begin
               root_in = root_ff + 4'd1;
            end
         end
         cpsi_pkg::StSend: begin
            if (rsp_tready) begin
               mask_in  = '0;
               low_in   = '0;
               count_in = '0;
               state_in = cpsi_pkg::StAccum;
            end
         end
         default: begin
            state_in = cpsi_pkg::StAccum;
         end
      endcase
   end

   // Control state and chord accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpsi_pkg::StAccum;
         mask_ff  <= '0;
         low_ff   <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         low_ff   <= low_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   // Scan payload and result register
   always_ff @(posedge clock) begin
      bass_ff      <= bass_in;
      root_ff      <= root_in;
      best_ob_ff   <= best_ob_in;
      lead_rank_ff <= lead_rank_in;
      lead_root_ff <= lead_root_in;
      named_ff     <= named_in;
      qual_ff      <= qual_in;
      root_out_ff  <= root_out_in;
      bass_out_ff  <= bass_out_in;
   end

   assign rsp_tdata = {bass_out_ff, root_out_ff, qual_ff, named_ff};

   // Checks on the sequencer and result encoding
   `CPSI_ASSERT_SAME(a_busy_while_result, clock, reset, rsp_tvalid, !req_tready, "request taken while result pending")
   `CPSI_ASSERT_NEXT(a_scan_runs, clock, reset, (state_ff == cpsi_pkg::StScan) && (root_ff != cpsi_pkg::LastClass), state_ff == cpsi_pkg::StScan, "root scan ended early")
   `CPSI_ASSERT_SAME(a_named_has_quality, clock, reset, rsp_tvalid && rsp_tdata[0], (rsp_tdata[5:1] != cpsi_pkg::QualNone) && (rsp_tdata[10:6] != cpsi_pkg::NoClass), "named chord lacks quality or root")
   `CPSI_ASSERT_SAME(a_unnamed_empty, clock, reset, rsp_tvalid && !rsp_tdata[0], (rsp_tdata[5:1] == cpsi_pkg::QualNone) && (rsp_tdata[10:6] == cpsi_pkg::NoClass), "unnamed chord carries quality or root")

endmodule

`default_nettype wire
